>>> rtl/assert_macros.svh
// Shared assertion macros for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define BFSP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset too.
`define BFSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/bfsp_pkg.sv
package bfsp_pkg;

  localparam int MAX_NODES   = 32;
  localparam int MAX_EDGES   = 128;
  localparam int WEIGHT_BITS = 24;
  localparam int DIST_W      = 32;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int NC_W        = $clog2(MAX_NODES + 1);
  localparam int EDGE_AW     = $clog2(MAX_EDGES);
  localparam int EDGE_CW     = $clog2(MAX_EDGES + 1);

  typedef enum logic [1:0] {
    REQ_ADD = 2'd0,
    REQ_UPD = 2'd1,
    REQ_RUN = 2'd2,
    REQ_CLR = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_RANGE  = 3'd2,
    ST_NEGCYC = 3'd3,
    ST_DIST   = 3'd4
  } status_t;

  typedef struct packed {
    logic [NODE_W-1:0]             from_node;
    logic [NODE_W-1:0]             to_node;
    logic signed [WEIGHT_BITS-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic               take;
    logic               edge_clear;
    logic               edge_append;
    logic               upd_wr;
    logic [EDGE_AW-1:0] edge_rd_idx;
    logic               run_init;
    logic               relax_wr;
    logic               emit_sel;
    logic [NODE_W-1:0]  emit_node;
    logic               out_load;
    status_t            out_code;
    logic               out_last;
  } cmd_t;

  typedef struct packed {
    logic               src_ok;
    logic               dst_ok;
    logic               full;
    logic               match;
    logic               relax;
    logic               out_free;
    logic [EDGE_CW-1:0] edge_count;
    logic [NC_W-1:0]    node_count;
  } stat_t;

endpackage

>>> rtl/bellman_ford_shortest_paths_core.sv
// Single-source shortest paths over a stored directed edge table.
// Input channel (in_valid/in_ready) takes one request beat: add edge, set
// weight of matching edges, run from src_node, or clear the table.
// Output channel (out_valid/out_ready) returns result beats; last marks the
// final beat of a request. A run returns one beat per node, or a single
// negative-cycle or range-error beat.
// cfg_wr_en/cfg_wr_data write node_count; write only while idle.
// Add and clear: result appears in the cycle after acceptance; a new request is taken
// every cycle while the receiver keeps up.
// Update: reads each stored edge and rewrites the weight of matching edges.
// Run: a setup step, then per stored edge the states edge read, distance
// read, sum and relax, for up to node_count-1 relax passes plus the check
// pass, then a read and a load per node result; the edge steps follow from
// the single read port of the edge table and the read-add-compare-write of distances.
// Reset clears the edge count, reachable bits and node_count (to 1).
// A stalled receiver holds the result register; no request is taken until
// the held beat is gone.
module bellman_ford_shortest_paths_core (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_wr_en,
  input  logic [bfsp_pkg::NC_W-1:0]                cfg_wr_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [1:0]                               req_type,
  input  logic [bfsp_pkg::NODE_W-1:0]              src_node,
  input  logic [bfsp_pkg::NODE_W-1:0]              dst_node,
  input  logic signed [bfsp_pkg::WEIGHT_BITS-1:0]  weight,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [2:0]                               status,
  output logic [bfsp_pkg::NODE_W-1:0]              node_index,
  output logic signed [bfsp_pkg::DIST_W-1:0]       distance,
  output logic                                     reachable,
  output logic                                     last
);

  bfsp_pkg::cmd_t  cmd;
  bfsp_pkg::stat_t st;

  bfsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .st       (st),
    .cmd      (cmd)
  );

  bfsp_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .src_node    (src_node),
    .dst_node    (dst_node),
    .weight      (weight),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .node_index  (node_index),
    .distance    (distance),
    .reachable   (reachable),
    .last        (last)
  );

endmodule

>>> rtl/bfsp_ram.sv
module bfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/bfsp_ctrl.sv
module bfsp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           req_type,
  input  bfsp_pkg::stat_t      st,
  output bfsp_pkg::cmd_t       cmd
);

  typedef enum logic [12:0] {
    S_IDLE       = 13'b0000000000001,
    S_UPD_RD     = 13'b0000000000010,
    S_UPD_WR     = 13'b0000000000100,
    S_RUN_INIT   = 13'b0000000001000,
    S_PASS_START = 13'b0000000010000,
    S_E_RD       = 13'b0000000100000,
    S_E_DRD      = 13'b0000001000000,
    S_E_SUM      = 13'b0000010000000,
    S_E_REL      = 13'b0000100000000,
    S_PASS_END   = 13'b0001000000000,
    S_EMIT_RD    = 13'b0010000000000,
    S_EMIT_LD    = 13'b0100000000000,
    S_DONE       = 13'b1000000000000
  } state_t;

  state_t                              state, state_next;
  logic [bfsp_pkg::EDGE_CW-1:0]        idx;
  logic [bfsp_pkg::NC_W-1:0]           rnd;
  logic [bfsp_pkg::NODE_W-1:0]         n;
  logic                                changed;
  logic                                checking;
  bfsp_pkg::status_t                   done_code;
  logic                                idx_end;
  logic                                emit_last;
  logic                                rnd_limit;

  assign idx_end   = (idx == st.edge_count);
  assign emit_last = ((bfsp_pkg::NC_W'(n) + bfsp_pkg::NC_W'(1)) == st.node_count);
  assign rnd_limit = ((rnd + bfsp_pkg::NC_W'(1)) >= st.node_count);

  always_comb begin
    cmd             = '0;
    cmd.edge_rd_idx = idx[bfsp_pkg::EDGE_AW-1:0];
    cmd.emit_node   = n;
    cmd.out_code    = bfsp_pkg::ST_OK;
    cmd.out_last    = 1'b1;
    in_ready        = 1'b0;
    state_next      = state;
    unique case (state)
      S_IDLE: begin
        in_ready = st.out_free;
        if (in_valid && st.out_free) begin
          cmd.take = 1'b1;
          unique case (bfsp_pkg::req_t'(req_type))
            bfsp_pkg::REQ_CLR: begin
              cmd.edge_clear = 1'b1;
              cmd.out_load   = 1'b1;
            end
            bfsp_pkg::REQ_ADD: begin
              cmd.out_load = 1'b1;
              if (!(st.src_ok && st.dst_ok)) begin
                cmd.out_code = bfsp_pkg::ST_RANGE;
              end else if (st.full) begin
                cmd.out_code = bfsp_pkg::ST_FULL;
              end else begin
                cmd.edge_append = 1'b1;
              end
            end
            bfsp_pkg::REQ_UPD: begin
              if (!(st.src_ok && st.dst_ok)) begin
                cmd.out_load = 1'b1;
                cmd.out_code = bfsp_pkg::ST_RANGE;
              end else begin
                state_next = S_UPD_RD;
              end
            end
            bfsp_pkg::REQ_RUN: begin
              if (!st.src_ok) begin
                cmd.out_load = 1'b1;
                cmd.out_code = bfsp_pkg::ST_RANGE;
              end else begin
                state_next = S_RUN_INIT;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_UPD_RD:     state_next = idx_end ? S_DONE : S_UPD_WR;
      S_UPD_WR: begin
        cmd.upd_wr = st.match;
        state_next = S_UPD_RD;
      end
      S_RUN_INIT: begin
        cmd.run_init = 1'b1;
        state_next   = S_PASS_START;
      end
      S_PASS_START: state_next = S_E_RD;
      S_E_RD:       state_next = idx_end ? S_PASS_END : S_E_DRD;
      S_E_DRD:      state_next = S_E_SUM;
      S_E_SUM:      state_next = S_E_REL;
      S_E_REL: begin
        cmd.relax_wr = st.relax && !checking;
        state_next   = S_E_RD;
      end
      S_PASS_END: begin
        if (checking) begin
          state_next = changed ? S_DONE : S_EMIT_RD;
        end else begin
          state_next = S_PASS_START;
        end
      end
      S_EMIT_RD: begin
        cmd.emit_sel = 1'b1;
        state_next   = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.emit_sel = 1'b1;
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_code = bfsp_pkg::ST_DIST;
          cmd.out_last = emit_last;
          state_next   = emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_code = done_code;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      rnd       <= '0;
      n         <= '0;
      changed   <= 1'b0;
      checking  <= 1'b0;
      done_code <= bfsp_pkg::ST_OK;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          idx       <= '0;
          done_code <= bfsp_pkg::ST_OK;
        end
        S_UPD_WR: idx <= idx + 1'b1;
        S_RUN_INIT: begin
          rnd      <= '0;
          idx      <= '0;
          changed  <= 1'b0;
          checking <= 1'b0;
        end
        S_PASS_START: begin
          if (!checking && rnd_limit) begin
            checking <= 1'b1;
          end
        end
        S_E_REL: begin
          changed <= changed | st.relax;
          idx     <= idx + 1'b1;
        end
        S_PASS_END: begin
          if (checking) begin
            n         <= '0;
            done_code <= bfsp_pkg::ST_NEGCYC;
          end else begin
            rnd     <= rnd + 1'b1;
            idx     <= '0;
            changed <= 1'b0;
            if (!changed) begin
              checking <= 1'b1;
            end
          end
        end
        S_EMIT_LD: begin
          if (st.out_free) begin
            n <= n + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/bfsp_dpath.sv
module bfsp_dpath (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_wr_en,
  input  logic [bfsp_pkg::NC_W-1:0]                cfg_wr_data,
  input  logic [bfsp_pkg::NODE_W-1:0]              src_node,
  input  logic [bfsp_pkg::NODE_W-1:0]              dst_node,
  input  logic signed [bfsp_pkg::WEIGHT_BITS-1:0]  weight,
  input  bfsp_pkg::cmd_t                           cmd,
  output bfsp_pkg::stat_t                          st,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [2:0]                               status,
  output logic [bfsp_pkg::NODE_W-1:0]              node_index,
  output logic signed [bfsp_pkg::DIST_W-1:0]       distance,
  output logic                                     reachable,
  output logic                                     last
);

  logic [bfsp_pkg::NC_W-1:0]              node_count;
  logic [bfsp_pkg::NC_W-1:0]              nc_next;
  logic [bfsp_pkg::EDGE_CW-1:0]           edge_count;
  logic [bfsp_pkg::NODE_W-1:0]            req_src;
  logic [bfsp_pkg::NODE_W-1:0]            req_dst;
  logic signed [bfsp_pkg::WEIGHT_BITS-1:0] req_w;
  logic [bfsp_pkg::MAX_NODES-1:0]         reached;

  bfsp_pkg::edge_t                        e_q, e_wdata;
  logic                                   e_we;
  logic [bfsp_pkg::EDGE_AW-1:0]           e_waddr;

  logic                                   d_we;
  logic [bfsp_pkg::NODE_W-1:0]            d_waddr;
  logic signed [bfsp_pkg::DIST_W-1:0]     d_wdata;
  logic signed [bfsp_pkg::DIST_W-1:0]     dist_u, dist_v;
  logic [bfsp_pkg::NODE_W-1:0]            rd_v;

  logic signed [bfsp_pkg::DIST_W:0]       sum;
  logic signed [bfsp_pkg::DIST_W-1:0]     cand;

  always_comb begin
    nc_next = cfg_wr_data;
    if (cfg_wr_data == '0) begin
      nc_next = bfsp_pkg::NC_W'(1);
    end else if (cfg_wr_data > bfsp_pkg::NC_W'(bfsp_pkg::MAX_NODES)) begin
      nc_next = bfsp_pkg::NC_W'(bfsp_pkg::MAX_NODES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= bfsp_pkg::NC_W'(1);
      edge_count <= '0;
      reached    <= '0;
    end else begin
      if (cfg_wr_en) begin
        node_count <= nc_next;
      end
      if (cmd.edge_clear) begin
        edge_count <= '0;
      end else if (cmd.edge_append) begin
        edge_count <= edge_count + 1'b1;
      end
      if (cmd.run_init) begin
        reached <= bfsp_pkg::MAX_NODES'(1) << req_src;
      end else if (cmd.relax_wr) begin
        reached[e_q.to_node] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_src <= src_node;
      req_dst <= dst_node;
      req_w   <= weight;
    end
  end

  // edge table
  always_comb begin
    e_we    = cmd.edge_append || cmd.upd_wr;
    e_waddr = cmd.edge_append ? edge_count[bfsp_pkg::EDGE_AW-1:0] : cmd.edge_rd_idx;
    if (cmd.edge_append) begin
      e_wdata = '{from_node: src_node, to_node: dst_node, weight: weight};
    end else begin
      e_wdata = '{from_node: e_q.from_node, to_node: e_q.to_node, weight: req_w};
    end
  end

  bfsp_ram #(
    .WIDTH($bits(bfsp_pkg::edge_t)),
    .DEPTH(bfsp_pkg::MAX_EDGES)
  ) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (cmd.edge_rd_idx),
    .rdata (e_q)
  );

  // distance store, one copy per read port
  assign d_we    = cmd.run_init || cmd.relax_wr;
  assign d_waddr = cmd.run_init ? req_src : e_q.to_node;
  assign d_wdata = cmd.run_init ? '0 : cand;
  assign rd_v    = cmd.emit_sel ? cmd.emit_node : e_q.to_node;

  bfsp_ram #(
    .WIDTH(bfsp_pkg::DIST_W),
    .DEPTH(bfsp_pkg::MAX_NODES)
  ) u_dist_u (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (e_q.from_node),
    .rdata (dist_u)
  );

  bfsp_ram #(
    .WIDTH(bfsp_pkg::DIST_W),
    .DEPTH(bfsp_pkg::MAX_NODES)
  ) u_dist_v (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (rd_v),
    .rdata (dist_v)
  );

  // saturating candidate
  assign sum = (bfsp_pkg::DIST_W+1)'(dist_u) + (bfsp_pkg::DIST_W+1)'(e_q.weight);

  always_ff @(posedge clk) begin
    if (sum[bfsp_pkg::DIST_W] != sum[bfsp_pkg::DIST_W-1]) begin
      cand <= sum[bfsp_pkg::DIST_W] ? {1'b1, {(bfsp_pkg::DIST_W-1){1'b0}}}
                                    : {1'b0, {(bfsp_pkg::DIST_W-1){1'b1}}};
    end else begin
      cand <= sum[bfsp_pkg::DIST_W-1:0];
    end
  end

  always_comb begin
    st.src_ok     = bfsp_pkg::NC_W'(src_node) < node_count;
    st.dst_ok     = bfsp_pkg::NC_W'(dst_node) < node_count;
    st.full       = edge_count == bfsp_pkg::EDGE_CW'(bfsp_pkg::MAX_EDGES);
    st.match      = (e_q.from_node == req_src) && (e_q.to_node == req_dst);
    st.relax      = (bfsp_pkg::NC_W'(e_q.from_node) < node_count)
                 && (bfsp_pkg::NC_W'(e_q.to_node) < node_count)
                 && reached[e_q.from_node]
                 && (!reached[e_q.to_node] || (cand < dist_v));
    st.out_free   = !out_valid || out_ready;
    st.edge_count = edge_count;
    st.node_count = node_count;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= cmd.out_code;
      last   <= cmd.out_last;
      if (cmd.out_code == bfsp_pkg::ST_DIST) begin
        node_index <= cmd.emit_node;
        reachable  <= reached[cmd.emit_node];
        distance   <= reached[cmd.emit_node] ? dist_v : '0;
      end else begin
        node_index <= '0;
        reachable  <= 1'b0;
        distance   <= '0;
      end
    end
  end

endmodule

>>> rtl/bfsp_checker.sv
`include "assert_macros.svh"

module bfsp_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [2:0]                         status,
  input logic [bfsp_pkg::NODE_W-1:0]        node_index,
  input logic signed [bfsp_pkg::DIST_W-1:0] distance,
  input logic                               last
);

  `BFSP_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result beat dropped")
  `BFSP_ASSERT(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(status) && $stable(node_index) && $stable(distance), "stalled result changed")
  `BFSP_ASSERT(a_stall_blocks, clk, rst, out_valid && !out_ready |-> !in_ready, "request taken while result stalled")
  `BFSP_ASSERT(a_single_last, clk, rst, out_valid && status != bfsp_pkg::ST_DIST |-> last, "single result without last")
  `BFSP_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid, "result valid after reset")

endmodule

bind bellman_ford_shortest_paths_core bfsp_checker u_bfsp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .node_index (node_index),
  .distance   (distance),
  .last       (last)
);
